### hdl/trtpc_pkg.sv
package trtpc_pkg;

    localparam int ANGLE_W = 13;
    localparam int TOL_W   = 12;
    localparam int DEAD_W  = 16;
    localparam int WEIGHT_W = 4;
    localparam int TIME_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OP_W = 2;

    // Input tdata: target_first, target_second, angle_first, angle_second, now_ms.
    localparam int IN_PAYLOAD_W = 4 * ANGLE_W + TIME_W;
    localparam int IN_DATA_W    = ((IN_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_PAYLOAD_W = 5;
    localparam int OUT_DATA_W    = 8;

    // Angle differences span two angle ranges; the weighted sum of ten of them
    // needs four more bits, plus one of headroom.
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int ERR_W   = DIFF_W + 5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(10);

    localparam logic [TOL_W-1:0]    TOLERANCE_RST  = TOL_W'(80);
    localparam logic [TOL_W-1:0]    HYSTERESIS_RST = TOL_W'(48);
    localparam logic [DEAD_W-1:0]   DEAD_TIME_RST  = DEAD_W'(1000);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = WEIGHT_W'(7);

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_ABORT  = 2'd2,
        OP_SPARE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOLERANCE  = 2'd0,
        CFG_HYSTERESIS = 2'd1,
        CFG_DEAD_TIME  = 2'd2,
        CFG_WEIGHT     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic heading_lying;
        logic arrived;
        logic running;
        logic relay_two_on;
        logic relay_one_on;
    } result_t;

endpackage

### hdl/two_relay_tilt_position_controller_unit.sv
// Two-relay tilt position controller.
// Input items arrive on the s_axis stream: tuser carries the opcode (start, sample,
// abort) and tdata the two targets, the two measured angles and the millisecond time.
// Every input transaction yields exactly one result transaction on m_axis, carrying
// both relay levels, the running flag, the arrival pulse and the current heading.
// The cfg channel writes the tolerance, hysteresis, dead time and first weight by
// register index; it is always ready and should only be used while no item is pending.
// An accepted item is captured in an input register, evaluated against the controller
// state once the result register is free or being taken, and lands in the result
// register, from which it is offered on m_axis. One item per cycle is sustained while
// the receiver keeps m_axis_tready high: the state update is a single pass of one
// small multiply-add and a few compares.
// While the receiver stalls, the result register holds and the input register keeps
// one more item; s_axis_tready drops only when both are full.
// Reset clears the controller state and both relays and restores the register
// defaults (tolerance 80, hysteresis 48, dead time 1000 ms, first weight 7).
module two_relay_tilt_position_controller_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: target_first, target_second, angle_first, angle_second,
    // now_ms, zero fill.
    input  logic [trtpc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [trtpc_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: relay_one_on, relay_two_on, running, arrived,
    // heading_lying, zero fill.
    output logic [trtpc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [trtpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [trtpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import trtpc_pkg::*;

    logic [TOL_W-1:0]    tolerance_reg;
    logic [TOL_W-1:0]    hysteresis_reg;
    logic [DEAD_W-1:0]   dead_time_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic                     in_valid_reg;
    logic [IN_PAYLOAD_W-1:0]  in_data_reg;
    logic [OP_W-1:0]          in_op_reg;

    logic       out_valid_reg;
    result_t    out_reg;

    logic                active_reg, active_next;
    logic                lying_reg, lying_next;
    logic                waiting_reg, waiting_next;
    logic [TIME_W-1:0]   wait_start_reg, wait_start_next;
    logic [ANGLE_W-1:0]  target_first_reg, target_first_next;
    logic [ANGLE_W-1:0]  target_second_reg, target_second_next;
    logic                relay_one_reg, relay_one_next;
    logic                relay_two_reg, relay_two_next;
    logic                arrived_next;

    logic advance;
    logic fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // Unpacked fields of the registered item.
    logic signed [ANGLE_W-1:0] t1_in, t2_in, a1_in, a2_in;
    logic [TIME_W-1:0]         now_in;
    opcode_t                   op_in;

    assign t1_in  = in_data_reg[ANGLE_W-1:0];
    assign t2_in  = in_data_reg[2*ANGLE_W-1:ANGLE_W];
    assign a1_in  = in_data_reg[3*ANGLE_W-1:2*ANGLE_W];
    assign a2_in  = in_data_reg[4*ANGLE_W-1:3*ANGLE_W];
    assign now_in = in_data_reg[4*ANGLE_W+TIME_W-1:4*ANGLE_W];
    assign op_in  = opcode_t'(in_op_reg);

    // A start item measures against its own targets, a sample against the stored ones.
    logic signed [ANGLE_W-1:0]  ref1, ref2;
    logic signed [DIFF_W-1:0]   diff1, diff2;
    logic [WEIGHT_W-1:0]        w1, w2;
    logic signed [ERR_W-1:0]    err, tol_pos, tol_neg, band_pos, band_neg;
    logic                       in_tol;
    logic [TIME_W-1:0]          elapsed;

    always_comb
    begin
        ref1 = (op_in == OP_START) ? t1_in : $signed(target_first_reg);
        ref2 = (op_in == OP_START) ? t2_in : $signed(target_second_reg);
        diff1 = DIFF_W'(ref1) - DIFF_W'(a1_in);
        diff2 = DIFF_W'(ref2) - DIFF_W'(a2_in);
        w1 = (weight_reg > WEIGHT_FULL) ? WEIGHT_FULL : weight_reg;
        w2 = WEIGHT_FULL - w1;
        err = ERR_W'(diff1) * $signed({1'b0, w1}) + ERR_W'(diff2) * $signed({1'b0, w2});
        tol_pos  = $signed(ERR_W'(tolerance_reg) * ERR_W'(10));
        band_pos = $signed((ERR_W'(tolerance_reg) + ERR_W'(hysteresis_reg)) * ERR_W'(10));
        tol_neg  = -tol_pos;
        band_neg = -band_pos;
        in_tol   = (err <= tol_pos) && (err >= tol_neg);
        elapsed  = now_in - wait_start_reg;
    end

    always_comb
    begin
        active_next        = active_reg;
        lying_next         = lying_reg;
        waiting_next       = waiting_reg;
        wait_start_next    = wait_start_reg;
        target_first_next  = target_first_reg;
        target_second_next = target_second_reg;
        relay_one_next     = relay_one_reg;
        relay_two_next     = relay_two_reg;
        arrived_next       = 1'b0;
        case (op_in)
            OP_START:
            begin
                target_first_next  = t1_in;
                target_second_next = t2_in;
                if (in_tol)
                begin
                    active_next  = 1'b0;
                    arrived_next = 1'b1;
                end
                else
                begin
                    lying_next   = (err > 0);
                    waiting_next = 1'b0;
                    active_next  = 1'b1;
                end
            end
            OP_SAMPLE:
            begin
                if (active_reg && !waiting_reg)
                begin
                    if (!lying_reg && err < band_neg)
                    begin
                        relay_one_next  = 1'b0;
                        wait_start_next = now_in;
                        waiting_next    = 1'b1;
                    end
                    else if (lying_reg && err > band_pos)
                    begin
                        relay_two_next  = 1'b0;
                        wait_start_next = now_in;
                        waiting_next    = 1'b1;
                    end
                    else if (in_tol)
                    begin
                        relay_one_next = 1'b0;
                        relay_two_next = 1'b0;
                        active_next    = 1'b0;
                        arrived_next   = 1'b1;
                    end
                end
                else if (active_reg && elapsed >= TIME_W'(dead_time_reg))
                begin
                    // Dead time is over: energize the opposite relay and turn around.
                    if (!lying_reg)
                    begin
                        relay_two_next = 1'b1;
                        lying_next     = 1'b1;
                    end
                    else
                    begin
                        relay_one_next = 1'b1;
                        lying_next     = 1'b0;
                    end
                    waiting_next = 1'b0;
                end
            end
            OP_ABORT:
            begin
                if (active_reg)
                begin
                    active_next    = 1'b0;
                    relay_one_next = 1'b0;
                    relay_two_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg     <= TOLERANCE_RST;
            hysteresis_reg    <= HYSTERESIS_RST;
            dead_time_reg     <= DEAD_TIME_RST;
            weight_reg        <= WEIGHT_RST;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            active_reg        <= 1'b0;
            lying_reg         <= 1'b0;
            waiting_reg       <= 1'b0;
            wait_start_reg    <= '0;
            target_first_reg  <= '0;
            target_second_reg <= '0;
            relay_one_reg     <= 1'b0;
            relay_two_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_TOLERANCE:  tolerance_reg  <= cfg_data[TOL_W-1:0];
                    CFG_HYSTERESIS: hysteresis_reg <= cfg_data[TOL_W-1:0];
                    CFG_DEAD_TIME:  dead_time_reg  <= cfg_data[DEAD_W-1:0];
                    CFG_WEIGHT:     weight_reg     <= cfg_data[WEIGHT_W-1:0];
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg     <= 1'b1;
                active_reg        <= active_next;
                lying_reg         <= lying_next;
                waiting_reg       <= waiting_next;
                wait_start_reg    <= wait_start_next;
                target_first_reg  <= target_first_next;
                target_second_reg <= target_second_next;
                relay_one_reg     <= relay_one_next;
                relay_two_reg     <= relay_two_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[IN_PAYLOAD_W-1:0];
            in_op_reg   <= s_axis_tuser;
        end
        if (fire)
        begin
            out_reg.relay_one_on  <= relay_one_next;
            out_reg.relay_two_on  <= relay_two_next;
            out_reg.running       <= active_next;
            out_reg.arrived       <= arrived_next;
            out_reg.heading_lying <= lying_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_PAYLOAD_W){1'b0}}, out_reg};

endmodule

### dv/two_relay_tilt_position_controller_unit_test.sv
`timescale 1ns / 1ps

module two_relay_tilt_position_controller_unit_test;
    import trtpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_COUNT = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int ANGLE_MAX = 2880;

    typedef struct packed {
        opcode_t            op;
        logic signed [12:0] tgt_a;
        logic signed [12:0] tgt_b;
        logic signed [12:0] ang_a;
        logic signed [12:0] ang_b;
        logic [31:0]        now;
        logic               typed;
        result_t            want;
    } directed_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic [OP_W-1:0]          s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // Typed expectation that travels beside the item currently on the input stream.
    logic                     drv_typed = 1'b0;
    result_t                  drv_want = '0;

    logic                     no_idle = 1'b0;
    logic [31:0]              clock_ms = 32'd0;
    int                       cycle_count = 0;
    int                       error_count = 0;

    // Controller model state and register copies.
    logic [TOL_W-1:0]         tol_reg = TOLERANCE_RST;
    logic [TOL_W-1:0]         hyst_reg = HYSTERESIS_RST;
    logic [DEAD_W-1:0]        dead_reg = DEAD_TIME_RST;
    logic [WEIGHT_W-1:0]      weight_reg = WEIGHT_RST;
    logic                     ctl_active = 1'b0;
    logic                     ctl_lying = 1'b0;
    logic                     ctl_waiting = 1'b0;
    logic [31:0]              wait_start = 32'd0;
    logic signed [12:0]       tgt_first = '0;
    logic signed [12:0]       tgt_second = '0;
    logic                     relay_one = 1'b0;
    logic                     relay_two = 1'b0;

    result_t                  expected_results[$];
    result_t                  popped;
    result_t                  predicted;
    directed_row_t            directed_items[$];

    two_relay_tilt_position_controller_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic result_t predict_relays(opcode_t op, logic signed [12:0] tf,
                                               logic signed [12:0] ts,
                                               logic signed [12:0] a1,
                                               logic signed [12:0] a2,
                                               logic [31:0] now);
        int          w1;
        int          err;
        int          tol10;
        int          band10;
        logic [31:0] elapsed;
        result_t     r;
        r = '0;
        w1 = (weight_reg > WEIGHT_FULL) ? 10 : int'(weight_reg);
        tol10 = int'(tol_reg) * 10;
        band10 = (int'(tol_reg) + int'(hyst_reg)) * 10;
        elapsed = now - wait_start;
        if (op == OP_START)
        begin
            tgt_first = tf;
            tgt_second = ts;
        end
        err = w1 * (int'(tgt_first) - int'(a1)) + (10 - w1) * (int'(tgt_second) - int'(a2));
        case (op)
            OP_START:
            begin
                if (err <= tol10 && err >= -tol10)
                begin
                    ctl_active = 1'b0;
                    r.arrived = 1'b1;
                end
                else
                begin
                    ctl_lying = (err > 0);
                    ctl_waiting = 1'b0;
                    ctl_active = 1'b1;
                end
            end
            OP_SAMPLE:
            begin
                if (ctl_active && !ctl_waiting)
                begin
                    if (!ctl_lying && err < -band10)
                    begin
                        relay_one = 1'b0;
                        wait_start = now;
                        ctl_waiting = 1'b1;
                    end
                    else if (ctl_lying && err > band10)
                    begin
                        relay_two = 1'b0;
                        wait_start = now;
                        ctl_waiting = 1'b1;
                    end
                    else if (err <= tol10 && err >= -tol10)
                    begin
                        relay_one = 1'b0;
                        relay_two = 1'b0;
                        ctl_active = 1'b0;
                        r.arrived = 1'b1;
                    end
                end
                else if (ctl_active && elapsed >= 32'(dead_reg))
                begin
                    // Dead time is over: energize the opposite relay and flip heading.
                    if (!ctl_lying)
                        relay_two = 1'b1;
                    else
                        relay_one = 1'b1;
                    ctl_lying = ~ctl_lying;
                    ctl_waiting = 1'b0;
                end
            end
            OP_ABORT:
            begin
                if (ctl_active)
                begin
                    ctl_active = 1'b0;
                    relay_one = 1'b0;
                    relay_two = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.relay_one_on = relay_one;
        r.relay_two_on = relay_two;
        r.running = ctl_active;
        r.heading_lying = ctl_lying;
        return r;
    endfunction

    function automatic int pick_angle(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > ANGLE_MAX)
            v = ANGLE_MAX;
        if (v < -ANGLE_MAX)
            v = -ANGLE_MAX;
        return v;
    endfunction

    function automatic directed_row_t make_row(opcode_t op, int tf, int ts, int a1, int a2,
                                               logic [31:0] now, logic typed,
                                               logic [4:0] want);
        directed_row_t row;
        row.op = op;
        row.tgt_a = 13'(tf);
        row.tgt_b = 13'(ts);
        row.ang_a = 13'(a1);
        row.ang_b = 13'(a2);
        row.now = now;
        row.typed = typed;
        row.want = result_t'(want);
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 100)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic check_result(result_t got, result_t want);
        if (got.relay_one_on !== want.relay_one_on)
            report_mismatch("relay_one_on", got.relay_one_on, want.relay_one_on);
        if (got.relay_two_on !== want.relay_two_on)
            report_mismatch("relay_two_on", got.relay_two_on, want.relay_two_on);
        if (got.running !== want.running)
            report_mismatch("running", got.running, want.running);
        if (got.arrived !== want.arrived)
            report_mismatch("arrived", got.arrived, want.arrived);
        if (got.heading_lying !== want.heading_lying)
            report_mismatch("heading_lying", got.heading_lying, want.heading_lying);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic push_item(opcode_t op, logic [12:0] tf, logic [12:0] ts, logic [12:0] a1,
                             logic [12:0] a2, logic [31:0] now, logic typed, result_t want);
        while (!no_idle && $urandom_range(0, 99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= IN_DATA_W'({now, a2, a1, ts, tf});
        drv_typed <= typed;
        drv_want <= want;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic program_regs(logic [TOL_W-1:0] tol, logic [TOL_W-1:0] hyst,
                                logic [DEAD_W-1:0] dead, logic [WEIGHT_W-1:0] w);
        logic [CFG_DATA_W-1:0] reg_values [4];
        reg_values[CFG_TOLERANCE] = CFG_DATA_W'(tol);
        reg_values[CFG_HYSTERESIS] = CFG_DATA_W'(hyst);
        reg_values[CFG_DEAD_TIME] = CFG_DATA_W'(dead);
        reg_values[CFG_WEIGHT] = CFG_DATA_W'(w);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data <= reg_values[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        int      sent;
        int      len;
        int      spread;
        int      t1;
        int      t2;
        opcode_t op;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 82)
            begin
                // A start followed by a run of samples, with occasional aborts, around the targets.
                t1 = pick_angle(0, ANGLE_MAX);
                t2 = pick_angle(0, ANGLE_MAX);
                case ($urandom_range(0, 3))
                    0: spread = 120;
                    1: spread = 400;
                    2: spread = 1500;
                    default: spread = ANGLE_MAX;
                endcase
                clock_ms += 32'($urandom_range(150, 250));
                push_item(OP_START, 13'(t1), 13'(t2), 13'(pick_angle(t1, ANGLE_MAX)),
                          13'(pick_angle(t2, ANGLE_MAX)), clock_ms, 1'b0, '0);
                sent++;
                len = $urandom_range(3, 30);
                repeat (len)
                begin
                    case ($urandom_range(0, 19))
                        0: clock_ms += 32'($urandom_range(0, 70000));
                        1: clock_ms = $urandom();
                        default: clock_ms += 32'($urandom_range(150, 250));
                    endcase
                    op = ($urandom_range(0, 99) < 3) ? OP_ABORT : OP_SAMPLE;
                    push_item(op, 13'($urandom()), 13'($urandom()),
                              13'(pick_angle(t1, spread)), 13'(pick_angle(t2, spread)),
                              clock_ms, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                op = opcode_t'($urandom_range(0, 3));
                push_item(op, 13'($urandom()), 13'($urandom()), 13'($urandom()),
                          13'($urandom()), $urandom(), 1'b0, '0);
                if (op != OP_SPARE)
                    sent++;
            end
        end
    endtask

    always @(negedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", int'(m_axis_tdata), 0);
                else
                begin
                    popped = expected_results.pop_front();
                    check_result(result_t'(m_axis_tdata[OUT_PAYLOAD_W-1:0]), popped);
                end
                if (m_axis_tdata[OUT_DATA_W-1:OUT_PAYLOAD_W] != '0)
                    report_mismatch("zero fill", int'(m_axis_tdata), 0);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = predict_relays(opcode_t'(s_axis_tuser), s_axis_tdata[12:0],
                                           s_axis_tdata[25:13], s_axis_tdata[38:26],
                                           s_axis_tdata[51:39], s_axis_tdata[83:52]);
                expected_results.push_back(drv_typed ? drv_want : predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TOLERANCE:  tol_reg = cfg_data[TOL_W-1:0];
                    CFG_HYSTERESIS: hyst_reg = cfg_data[TOL_W-1:0];
                    CFG_DEAD_TIME:  dead_reg = cfg_data[DEAD_W-1:0];
                    CFG_WEIGHT:     weight_reg = cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        // Default registers: tolerance band 800, reversal band 1280, first weight 7.
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 0, 0, 32'd0, 1'b1, 5'b00000));
        directed_items.push_back(make_row(OP_SPARE, 2880, -2880, 1, -1, 32'hFFFF_FFFF,
                                          1'b1, 5'b00000));
        directed_items.push_back(make_row(OP_ABORT, 0, 0, 0, 0, 32'd0, 1'b1, 5'b00000));
        directed_items.push_back(make_row(OP_START, 0, 0, 0, 0, 32'd0, 1'b1, 5'b01000));
        directed_items.push_back(make_row(OP_START, 2880, 2880, -2880, -2880, 32'd100,
                                          1'b1, 5'b10100));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, -2880, -2880, 32'd100, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, -2880, -2880, 32'd1099, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, -2880, -2880, 32'd1100, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 2880, 2880, 32'd1300, 1'b0, '0));
        directed_items.push_back(make_row(OP_START, -2880, -2880, 2880, 2880, 32'd1500,
                                          1'b0, '0));
        // The dead time spans the wrap of the millisecond counter.
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 2880, 2880, 32'hFFFF_FF00,
                                          1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 2880, 2880, 32'h0000_02E7,
                                          1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 2880, 2880, 32'h0000_02E8,
                                          1'b0, '0));
        directed_items.push_back(make_row(OP_ABORT, 0, 0, 0, 0, 32'd0, 1'b1, 5'b10000));
        directed_items.push_back(make_row(OP_ABORT, 0, 0, 0, 0, 32'd0, 1'b0, '0));
        directed_items.push_back(make_row(OP_START, 2000, 0, 0, 0, 32'd2000, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 1872, -128, 32'd2000, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 1871, -129, 32'd2000, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 1871, -129, 32'd3000, 1'b0, '0));
        directed_items.push_back(make_row(OP_SAMPLE, 0, 0, 2080, 80, 32'd3200, 1'b0, '0));
        directed_items.push_back(make_row(OP_START, 2000, 0, 1920, -80, 32'd3400, 1'b0, '0));
        directed_items.push_back(make_row(OP_START, 2000, 0, 1919, -81, 32'd3600, 1'b0, '0));

        clock_ms = $urandom();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_items[i])
            push_item(directed_items[i].op, directed_items[i].tgt_a, directed_items[i].tgt_b,
                      directed_items[i].ang_a, directed_items[i].ang_b, directed_items[i].now,
                      directed_items[i].typed, directed_items[i].want);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: program_regs('0, '0, '0, '0);
                1: program_regs(12'd2880, 12'd2880, 16'hFFFF, WEIGHT_FULL);
                2: program_regs(12'($urandom_range(0, 400)), 12'($urandom_range(0, 300)),
                                16'($urandom_range(0, 3000)), 4'd15);
                3: program_regs(TOLERANCE_RST, HYSTERESIS_RST, DEAD_TIME_RST, WEIGHT_RST);
                default:
                    program_regs(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 2880))
                                                             : 12'($urandom_range(0, 400)),
                                 12'($urandom_range(0, 300)),
                                 16'($urandom_range(0, 3000)),
                                 4'($urandom_range(0, 15)));
            endcase
            no_idle = (phase == 4);
            run_random(ITEMS_PER_PHASE);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
